>>> hw/rtl/bpu_pkg.sv
// Shared types and constants for the BMP pixel unpacker.
// No dependencies; imported by bpu_out_fifo and bmp_pixel_unpacker.
`timescale 1ns / 1ps

package bpu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // pixel depth modes; any other code decodes as 24 bpp
  localparam logic [1:0] MODE_4BPP  = 2'd0;
  localparam logic [1:0] MODE_8BPP  = 2'd1;
  localparam logic [1:0] MODE_24BPP = 2'd2;

  // item opcodes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // request kinds in the palette access queue
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_DIRECT = 2'd2;

  localparam logic [7:0]  NIBBLE_MASK  = 8'h0F;
  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;
  localparam int          OUT_DEPTH    = 4;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
    logic        frame_end;
  } pix_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  addr;
    logic [23:0] rgb;
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
    logic        frame_end;
  } req_t;

endpackage

>>> hw/rtl/bpu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bpu_out_fifo.sv
// Small output queue of finished pixels with a valid/stall read side.
// Depends on bpu_pkg (pix_t).
`timescale 1ns / 1ps

module bpu_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bpu_pkg::pix_t              push_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bpu_pkg::pix_t              out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import bpu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pix_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/bmp_pixel_unpacker.sv
// BMP pixel-array decoder (4/8/24 bpp, bottom-up, rows padded to 32 bits).
// Depends on bpu_pkg, bpu_ram (palette) and bpu_out_fifo (result queue).
//
//   port group  dir  handshake          carries
//   in_*        in   in_valid/in_stall  palette write or one pixel-array byte
//   out_*       out  out_valid/out_stall one RGB pixel with display x/y
//   cfg_*       in   cfg_we             mode, width, height registers
//
// 8 bpp, 24 bpp bytes and palette writes: one item per cycle while the result
// queue has room. 4 bpp bytes: the single palette read port does two lookups
// per byte, so the next byte is taken only as the second lookup issues.
// Reset (synchronous, rst_n low) gives 24 bpp, 1x1 image, counters at zero;
// the palette is not cleared. out_stall backs up the result queue, which
// stops palette reads and in turn raises in_stall.
`timescale 1ns / 1ps

module bmp_pixel_unpacker #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_we,
  input  logic [bpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpu_pkg::CFG_DATA_W-1:0] cfg_wdata,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [7:0]                     in_palette_index,
  input  logic [7:0]                     in_entry_red,
  input  logic [7:0]                     in_entry_green,
  input  logic [7:0]                     in_entry_blue,
  input  logic [7:0]                     in_data_byte,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [11:0]                    out_pixel_x,
  output logic [11:0]                    out_pixel_y,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           out_last_in_run,
  output logic                           out_frame_end
);
  import bpu_pkg::*;

  localparam int CW             = $clog2(MAX_WIDTH + 1);
  localparam int BW             = CW + 5;
  localparam int ROW_BYTES_MAX  = ((MAX_WIDTH * 24 + 31) / 32) * 4;
  localparam int RB_W           = $clog2(ROW_BYTES_MAX + 1);
  localparam int AW             = $clog2(PALETTE_DEPTH);
  localparam int FC_W           = $clog2(OUT_DEPTH + 1);

  // configuration registers
  logic [1:0]            cfg_mode_r;
  logic [CFG_DATA_W-1:0] cfg_width_r;
  logic [CFG_DATA_W-1:0] cfg_height_r;
  logic                  cfg_hit;

  // decode counters
  logic [CW-1:0]   col_r, col_nxt;
  logic [11:0]     row_r, row_nxt;
  logic [RB_W-1:0] rbc_r, rbc_nxt;
  logic [15:0]     part_r, part_nxt;
  logic [1:0]      phase_r, phase_nxt;

  logic [CW-1:0]   eff_w, w_m1, col_p1, col_p2;
  logic [12:0]     eff_h, h_m1;
  logic [BW-1:0]   row_bits;
  logic [RB_W-1:0] row_size, rbc_inc;
  logic [11:0]     y_disp;
  logic            last_row;

  // palette access queue
  req_t       q0_r, q1_r, e0, e1;
  logic [1:0] req_cnt_r, n_new;
  logic       in_acc, issue, space;

  // read stage
  logic        s1_v_r;
  req_t        s1_r;
  logic [23:0] ram_rdata;
  pix_t        push_pix, head_pix;
  logic [FC_W-1:0] fifo_cnt;
  logic        out_pop;

  // ---------------- configuration ----------------
  assign cfg_hit = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
                              cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= MODE_24BPP;
      cfg_width_r  <= CFG_DATA_W'(1);
      cfg_height_r <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   cfg_mode_r   <= cfg_wdata[1:0];
        REG_WIDTH:  cfg_width_r  <= cfg_wdata;
        REG_HEIGHT: cfg_height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      eff_h = 13'd1;
    end else if (cfg_height_r > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = cfg_height_r;
    end
  end

  always_comb begin
    case (cfg_mode_r)
      MODE_4BPP: row_bits = BW'(eff_w) << 2;
      MODE_8BPP: row_bits = BW'(eff_w) << 3;
      default:   row_bits = (BW'(eff_w) << 4) + (BW'(eff_w) << 3);
    endcase
  end

  // bytes per stored row, rounded up to a 32-bit boundary
  assign row_size = RB_W'(((row_bits + BW'(31)) >> 5) << 2);
  assign rbc_inc  = rbc_r + RB_W'(1);
  assign w_m1     = eff_w - CW'(1);
  assign col_p1   = col_r + CW'(1);
  assign col_p2   = col_r + CW'(2);
  assign h_m1     = eff_h - 13'd1;
  assign y_disp   = 12'(h_m1 - {1'b0, row_r});
  assign last_row = ({1'b0, row_r} == h_m1);

  function automatic req_t pix_req(input logic [CW-1:0] c, input logic [CW-1:0] wm1,
                                   input logic [11:0] y, input logic lrow);
    req_t r;
    r           = '0;
    r.x         = 12'(c);
    r.y         = y;
    r.frame_end = lrow && (c == wm1);
    return r;
  endfunction

  // ---------------- byte decode ----------------
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    e0        = '0;
    e1        = '0;
    n_new     = 2'd0;
    col_nxt   = col_r;
    row_nxt   = row_r;
    rbc_nxt   = rbc_r;
    part_nxt  = part_r;
    phase_nxt = phase_r;
    if (cfg_hit) begin
      col_nxt   = '0;
      row_nxt   = '0;
      rbc_nxt   = '0;
      part_nxt  = '0;
      phase_nxt = '0;
    end else if (in_acc) begin
      if (in_op == OP_PALETTE) begin
        if (32'(in_palette_index) < 32'(PALETTE_DEPTH)) begin
          e0.kind = KIND_WRITE;
          e0.addr = in_palette_index;
          e0.rgb  = {in_entry_red, in_entry_green, in_entry_blue};
          n_new   = 2'd1;
        end
      end else begin
        case (cfg_mode_r)
          MODE_4BPP: begin
            if (col_r < eff_w) begin
              e0      = pix_req(col_r, w_m1, y_disp, last_row);
              e0.kind = KIND_READ;
              e0.addr = in_data_byte >> 4;
              n_new   = 2'd1;
              col_nxt = col_p1;
              if (col_p1 < eff_w) begin
                e1      = pix_req(col_p1, w_m1, y_disp, last_row);
                e1.kind = KIND_READ;
                e1.addr = in_data_byte & NIBBLE_MASK;
                n_new   = 2'd2;
                col_nxt = col_p2;
              end
            end
          end
          MODE_8BPP: begin
            if (col_r < eff_w) begin
              e0 = pix_req(col_r, w_m1, y_disp, last_row);
              if (32'(in_data_byte) < 32'(PALETTE_DEPTH)) begin
                e0.kind = KIND_READ;
                e0.addr = in_data_byte;
              end else begin
                e0.kind = KIND_DIRECT;   // index beyond the palette reads black
              end
              n_new   = 2'd1;
              col_nxt = col_p1;
            end
          end
          default: begin
            if (col_r < eff_w) begin
              if (phase_r == 2'd0) begin
                part_nxt  = {8'h00, in_data_byte};
                phase_nxt = 2'd1;
              end else if (phase_r == 2'd1) begin
                part_nxt  = {in_data_byte, part_r[7:0]};
                phase_nxt = 2'd2;
              end else begin
                e0        = pix_req(col_r, w_m1, y_disp, last_row);
                e0.kind   = KIND_DIRECT;
                e0.rgb    = {in_data_byte, part_r[15:8], part_r[7:0]};
                n_new     = 2'd1;
                col_nxt   = col_p1;
                part_nxt  = '0;
                phase_nxt = 2'd0;
              end
            end
          end
        endcase

        if (n_new == 2'd1) begin
          e0.last = 1'b1;
        end else if (n_new == 2'd2) begin
          e1.last = 1'b1;
        end

        // padding bytes only advance the byte count
        rbc_nxt = rbc_inc;
        if (rbc_inc >= row_size) begin
          rbc_nxt   = '0;
          col_nxt   = '0;
          phase_nxt = 2'd0;
          part_nxt  = '0;
          row_nxt   = ({1'b0, row_r} + 13'd1 >= eff_h) ? '0 : row_r + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      rbc_r   <= '0;
      part_r  <= '0;
      phase_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rbc_r   <= rbc_nxt;
      part_r  <= part_nxt;
      phase_r <= phase_nxt;
    end
  end

  // ---------------- palette access queue ----------------
  // A new byte enters only once the queue drains this cycle, so requests stay
  // in item order and palette writes never pass earlier lookups.
  assign space    = (32'(fifo_cnt) + 32'(s1_v_r)) < OUT_DEPTH;
  assign issue    = (req_cnt_r != 2'd0) && (q0_r.kind == KIND_WRITE || space);
  assign in_stall = !((req_cnt_r == 2'd0) || (req_cnt_r == 2'd1 && issue));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cnt_r <= 2'd0;
      s1_v_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        req_cnt_r <= n_new;
      end else if (issue) begin
        req_cnt_r <= req_cnt_r - 2'd1;
      end
      s1_v_r <= issue && (q0_r.kind != KIND_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q0_r <= e0;
      q1_r <= e1;
    end else if (issue) begin
      q0_r <= q1_r;
    end
    if (issue) begin
      s1_r <= q0_r;
    end
  end

  bpu_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (issue && (q0_r.kind == KIND_WRITE)),
    .waddr (AW'(q0_r.addr)),
    .wdata (q0_r.rgb),
    .raddr (AW'(q0_r.addr)),
    .rdata (ram_rdata)
  );

  // ---------------- result queue ----------------
  always_comb begin
    push_pix.x         = s1_r.x;
    push_pix.y         = s1_r.y;
    push_pix.last      = s1_r.last;
    push_pix.frame_end = s1_r.frame_end;
    if (s1_r.kind == KIND_DIRECT) begin
      {push_pix.red, push_pix.green, push_pix.blue} = s1_r.rgb;
    end else begin
      {push_pix.red, push_pix.green, push_pix.blue} = ram_rdata;
    end
  end

  bpu_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data (push_pix),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head_pix),
    .count     (fifo_cnt)
  );

  assign out_pop         = out_valid && !out_stall;
  assign out_pixel_x     = head_pix.x;
  assign out_pixel_y     = head_pix.y;
  assign out_red         = head_pix.red;
  assign out_green       = head_pix.green;
  assign out_blue        = head_pix.blue;
  assign out_last_in_run = head_pix.last;
  assign out_frame_end   = head_pix.frame_end;

  // ---------------- assertions ----------------
  // the read stage never lands a pixel in a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (32'(fifo_cnt) < OUT_DEPTH || out_pop))
    else $error("result queue overflow");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= eff_w)
    else $error("column count beyond image width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < eff_h)
    else $error("row count beyond image height");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (req_cnt_r != 2'd3))
    else $error("request queue over two entries");

endmodule
